[rtl/bir_pkg.sv]
// Package for the bilinear image resizer.
// Holds field widths, register codes and reset values shared by the interfaces and the top level.
// No dependencies.
`default_nettype none

package bir_pkg;

  localparam int CFG_W   = 10;  // width of every size register
  localparam int PIX_W   = 8;   // gray value width
  localparam int DX_W    = 9;   // output column width
  localparam int DY_W    = 9;   // output row width
  localparam int APB_W   = 32;  // APB data width
  localparam int PADDR_W = 4;   // four registers at byte offsets 0, 4, 8, 12

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_t;

  localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 10'd512;
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 10'd512;
  localparam logic [CFG_W-1:0] DST_WIDTH_RST  = 10'd28;
  localparam logic [CFG_W-1:0] DST_HEIGHT_RST = 10'd28;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

endpackage

`default_nettype wire

[rtl/bir_req_if.sv]
// Request channel of the bilinear image resizer: valid/ready plus one command item.
// Depends on bir_pkg for the field widths.
`default_nettype none

interface bir_req_if import bir_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] pixel_in;
  logic [DX_W-1:0]  dst_x;
  logic [DY_W-1:0]  dst_y;

  modport source (output valid, cmd, pixel_in, dst_x, dst_y, input ready);
  modport sink   (input valid, cmd, pixel_in, dst_x, dst_y, output ready);
endinterface

`default_nettype wire

[rtl/bir_rsp_if.sv]
// Response channel of the bilinear image resizer: valid/ready plus one result item.
// Depends on bir_pkg for the field widths.
`default_nettype none

interface bir_rsp_if import bir_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             valid_res;

  modport source (output valid, pixel_out, valid_res, input ready);
  modport sink   (input valid, pixel_out, valid_res, output ready);
endinterface

`default_nettype wire

[rtl/bir_ram.sv]
// Generic single-port RAM with a registered read, used for the frame store.
// No dependencies.
`default_nettype none

module bir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 262144
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[rtl/bilinear_image_resizer.sv]
// Bilinear image resizer top level: config registers, load path, divider and blend sequencer.
// Depends on bir_pkg, bir_req_if, bir_rsp_if and bir_ram.
//
// The block holds one grayscale source frame in a single-port frame store and answers compute
// requests with one bilinearly interpolated output pixel each. Load transactions (cmd 0) are
// taken one per clock cycle while the block is idle and write the next raster position of the
// store; they give no response. A compute transaction (cmd 1) whose four neighbors lie inside
// the frame passes through the divide, check, blend and finish states. The bit-serial divider
// maps both output coordinates into the source in parallel, one quotient bit per cycle over
// NUM_W = DX_W + CFG_W + FRAC_BITS quotient bits. The check state tests the neighbors, the
// blend state issues the four neighbor reads through the single frame store port, one per
// cycle, and blends them on one shared multiplier, and the finish state loads the response
// register. A request whose neighbors fall outside the frame skips the blend state, and one
// with bad geometry goes straight to the finish state; both answer with a zero pixel and
// valid_res low. The next request is taken the cycle after the response register has been
// loaded, even if the response has not been picked up yet, so compute transactions never
// overlap; a response waiting in the register holds the next finished result back and stalls
// the input. The frame store is not cleared by reset; its contents are undefined until loaded.
`default_nettype none

module bilinear_image_resizer import bir_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]   pwdata,
  output logic      [APB_W-1:0]   prdata,
  output logic                    pready,
  bir_req_if.sink                 req,
  bir_rsp_if.source               rsp
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int FW     = $clog2(STORE_DEPTH + 1);
  localparam int XW     = $clog2(MAX_WIDTH + 1);
  localparam int YW     = $clog2(MAX_HEIGHT + 1);
  localparam int NUM_W  = DX_W + CFG_W + FRAC_BITS;
  localparam int QW     = NUM_W - FRAC_BITS;
  localparam int QW1    = QW + 1;
  localparam int CW     = $clog2(NUM_W);
  localparam int HW     = PIX_W + FRAC_BITS;
  localparam int VW     = PIX_W + 2 * FRAC_BITS;
  localparam int WW     = FRAC_BITS + 1;
  localparam int PW     = HW + WW;
  localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

  // Blend sequencer steps. Reads are issued in steps 0 to 3, the data comes back one step later.
  localparam logic [2:0] BS_START = 3'd0;
  localparam logic [2:0] BS_TL    = 3'd1;
  localparam logic [2:0] BS_TR    = 3'd2;
  localparam logic [2:0] BS_BL    = 3'd3;
  localparam logic [2:0] BS_BR    = 3'd4;
  localparam logic [2:0] BS_VTOP  = 3'd5;
  localparam logic [2:0] BS_VBOT  = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_CHK   = 5'b00100,
    ST_BLEND = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [FW-1:0]    frame_size;
  logic [AW-1:0]    load_pos;

  logic [NUM_W-1:0] qx, qy;
  logic [CFG_W-1:0] rx, ry;
  logic [CW-1:0]    div_cnt;

  logic [AW-1:0]    base;
  logic [CFG_W-1:0] left;
  logic [WW-1:0]    wx0, wx1, wy0, wy1;
  logic [2:0]       step;
  logic [HW-1:0]    hacc, top_r;
  logic [VW-1:0]    vacc;

  logic [PIX_W-1:0] res_pixel;
  logic             res_valid;
  logic             out_valid;
  logic [PIX_W-1:0] out_pixel;
  logic             out_vres;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [AW-1:0]    rd_addr;
  logic [PIX_W-1:0] ram_rdata;

  // ---------------------------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------------------------
  logic     cfg_we;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_WIDTH_RST;
      src_height <= SRC_HEIGHT_RST;
      dst_width  <= DST_WIDTH_RST;
      dst_height <= DST_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SRC_WIDTH:  src_width  <= pwdata[CFG_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[CFG_W-1:0];
        REG_DST_WIDTH:  dst_width  <= pwdata[CFG_W-1:0];
        REG_DST_HEIGHT: dst_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SRC_WIDTH:  prdata = APB_W'(src_width);
      REG_SRC_HEIGHT: prdata = APB_W'(src_height);
      REG_DST_WIDTH:  prdata = APB_W'(dst_width);
      REG_DST_HEIGHT: prdata = APB_W'(dst_height);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------------
  // Load path
  // ---------------------------------------------------------------------------------------------
  logic [XW-1:0] src_w_clamp;
  logic [YW-1:0] src_h_clamp;
  logic [FW-1:0] load_pos_inc;
  logic          req_acc, load_acc, comp_acc, bad_geom;

  assign src_w_clamp = (32'(src_width) > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(src_width);
  assign src_h_clamp = (32'(src_height) > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(src_height);
  assign frame_size  = FW'(src_w_clamp) * FW'(src_h_clamp);

  assign req.ready    = (state == ST_IDLE);
  assign req_acc      = req.valid && req.ready;
  assign load_acc     = req_acc && (req.cmd == CMD_LOAD);
  assign comp_acc     = req_acc && (req.cmd == CMD_COMPUTE);
  assign load_pos_inc = FW'(load_pos) + FW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
    end else if (load_acc) begin
      load_pos <= (load_pos_inc >= frame_size) ? '0 : AW'(load_pos_inc);
    end
  end

  assign bad_geom = (src_width == '0) || (src_height == '0) ||
                    (32'(src_width) > 32'(MAX_WIDTH)) || (32'(src_height) > 32'(MAX_HEIGHT)) ||
                    (dst_width == '0) || (dst_height == '0);

  // ---------------------------------------------------------------------------------------------
  // Coordinate divider: restoring division, one quotient bit per cycle for both axes.
  // ---------------------------------------------------------------------------------------------
  logic [CFG_W:0]   tx, ty;
  logic             gex, gey;
  logic [CFG_W-1:0] rx_next, ry_next;

  assign tx      = {rx, qx[NUM_W-1]};
  assign ty      = {ry, qy[NUM_W-1]};
  assign gex     = tx >= {1'b0, dst_width};
  assign gey     = ty >= {1'b0, dst_height};
  assign rx_next = gex ? CFG_W'(tx - {1'b0, dst_width}) : tx[CFG_W-1:0];
  assign ry_next = gey ? CFG_W'(ty - {1'b0, dst_height}) : ty[CFG_W-1:0];

  // ---------------------------------------------------------------------------------------------
  // Neighbor check on the quotients
  // ---------------------------------------------------------------------------------------------
  logic [QW-1:0] pos_x, pos_y;
  logic          outside;

  assign pos_x   = qx[NUM_W-1:FRAC_BITS];
  assign pos_y   = qy[NUM_W-1:FRAC_BITS];
  assign outside = (QW1'(pos_x) + QW1'(1) >= QW1'(src_width)) ||
                   (QW1'(pos_y) + QW1'(1) >= QW1'(src_height));

  // ---------------------------------------------------------------------------------------------
  // Blend datapath: one multiplier shared by all six products.
  // ---------------------------------------------------------------------------------------------
  logic [HW-1:0] mul_a;
  logic [WW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [VW-1:0] vsum;

  // Bottom row on bit 1 of the step, right column on bit 0.
  assign rd_addr = base + AW'(left) + (step[1] ? AW'(src_width) : AW'(0)) + AW'(step[0]);

  always_comb begin
    case (step)
      BS_TL:   begin mul_a = HW'(ram_rdata); mul_b = wx0; end
      BS_TR:   begin mul_a = HW'(ram_rdata); mul_b = wx1; end
      BS_BL:   begin mul_a = HW'(ram_rdata); mul_b = wx0; end
      BS_BR:   begin mul_a = HW'(ram_rdata); mul_b = wx1; end
      BS_VTOP: begin mul_a = top_r;          mul_b = wy0; end
      BS_VBOT: begin mul_a = hacc;           mul_b = wy1; end
      default: begin mul_a = '0;             mul_b = '0;  end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);
  assign vsum = vacc + VW'(prod);

  // ---------------------------------------------------------------------------------------------
  // Frame store
  // ---------------------------------------------------------------------------------------------
  assign ram_we   = load_acc;
  assign ram_addr = (state == ST_BLEND) ? rd_addr : load_pos;

  bir_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req.pixel_in),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------------
  logic out_free;

  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
      step    <= BS_START;
    end else begin
      case (state)
        ST_IDLE: begin
          if (comp_acc) begin
            div_cnt <= '0;
            state   <= bad_geom ? ST_FIN : ST_DIV;
          end
        end
        ST_DIV: begin
          div_cnt <= div_cnt + CW'(1);
          if (div_cnt == CW'(NUM_W - 1)) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          step  <= BS_START;
          state <= outside ? ST_FIN : ST_BLEND;
        end
        ST_BLEND: begin
          step <= step + 3'd1;
          if (step == BS_VBOT) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        qx        <= (NUM_W'(req.dst_x) * NUM_W'(src_width)) << FRAC_BITS;
        qy        <= (NUM_W'(req.dst_y) * NUM_W'(src_height)) << FRAC_BITS;
        rx        <= '0;
        ry        <= '0;
        res_pixel <= '0;
        res_valid <= 1'b0;
      end
      ST_DIV: begin
        qx <= {qx[NUM_W-2:0], gex};
        qy <= {qy[NUM_W-2:0], gey};
        rx <= rx_next;
        ry <= ry_next;
      end
      ST_CHK: begin
        base <= AW'(pos_y) * AW'(src_width);
        left <= CFG_W'(pos_x);
        wx1  <= WW'(qx[FRAC_BITS-1:0]);
        wx0  <= ONE - WW'(qx[FRAC_BITS-1:0]);
        wy1  <= WW'(qy[FRAC_BITS-1:0]);
        wy0  <= ONE - WW'(qy[FRAC_BITS-1:0]);
      end
      ST_BLEND: begin
        case (step)
          BS_TL: hacc <= HW'(prod);
          BS_TR: hacc <= hacc + HW'(prod);
          BS_BL: begin
            top_r <= hacc;
            hacc  <= HW'(prod);
          end
          BS_BR:   hacc <= hacc + HW'(prod);
          BS_VTOP: vacc <= VW'(prod);
          BS_VBOT: begin
            res_pixel <= vsum[VW-1:2*FRAC_BITS];
            res_valid <= 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------------------------
  // Response register
  // ---------------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_pixel <= res_pixel;
      out_vres  <= res_valid;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.pixel_out = out_pixel;
  assign rsp.valid_res = out_vres;

  // ---------------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------------
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.valid_res |-> rsp.pixel_out == '0)
    else $error("invalid response carries a nonzero pixel");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_IDLE)
    else $error("frame store written outside the idle state");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_free |=> rsp.valid && state == ST_IDLE)
    else $error("finished result was not moved to the response register");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_BLEND |-> step <= BS_VBOT)
    else $error("blend step out of range");

endmodule

`default_nettype wire
